[design/dense_linear_solver_scaled_pivot_assert.svh]
// assertion macros for the scaled pivot solver
// used by the top level only, no other dependencies
`ifndef DENSE_LINEAR_SOLVER_SCALED_PIVOT_ASSERT_SVH
`define DENSE_LINEAR_SOLVER_SCALED_PIVOT_ASSERT_SVH
`ifndef SYNTHESIS
`define DLSSP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dlssp assertion failed");
`define DLSSP_ASSERT_ALL(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("dlssp check failed");
`else
`define DLSSP_ASSERT(lbl, prop)
`define DLSSP_ASSERT_ALL(lbl, prop)
`endif
`endif

[design/dlssp_pkg.sv]
// shared constants, types and q16.16 helpers for the scaled pivot solver
// no dependencies
package dlssp_pkg;

    localparam int SIZE     = 8;
    localparam int COLS     = SIZE + 1;
    localparam int IDX_W    = $clog2(SIZE);
    localparam int COL_W    = IDX_W + 1;
    localparam int DEPTH    = SIZE * COLS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int ROW_IN_W = 4;
    localparam int COL_IN_W = 5;
    localparam int DATA_W   = 32;
    localparam int Q_DEPTH  = 4;
    localparam int QP_W     = $clog2(Q_DEPTH);
    localparam int DV_W     = 48;
    localparam int CNT_W    = $clog2(DV_W);

    localparam logic signed [DATA_W-1:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] QMIN = 32'sh8000_0000;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIZE - 1);
    localparam logic [IDX_W-1:0] PEN_IDX  = IDX_W'(SIZE - 2);
    localparam logic [COL_W-1:0] RHS_COL  = COL_W'(SIZE);

    typedef struct packed {
        logic                     wr;
        logic [IDX_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } elem_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic                     dz;
        logic signed [DATA_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_SC_RD, S_SC_ACC,
        S_PV_INIT, S_PV_ORD, S_PV_DIV, S_PV_WAIT,
        S_SW_A, S_SW_B, S_SW_C,
        S_EL_ORD, S_EL_PRD, S_EL_DIV, S_EL_DWT, S_EL_RB, S_EL_RA, S_EL_MUL,
        S_EL_WR, S_EL_WM,
        S_FW_ORD, S_FW_RB, S_FW_RC, S_FW_MUL, S_FW_WR,
        S_BK_ORD, S_BK_SUM, S_BK_RD, S_BK_MUL, S_BK_ACC, S_BK_DRD, S_BK_DIV,
        S_BK_DWT,
        S_OUT
    } seq_state_t;

    function automatic logic signed [DATA_W-1:0] q_sat48(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF)
            return QMAX;
        if (v < 48'shFFFF_8000_0000)
            return QMIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] q_abs(input logic signed [DATA_W-1:0] a);
        if (a == QMIN)
            return QMAX;
        return (a < 0) ? -a : a;
    endfunction

    function automatic logic signed [DATA_W-1:0] q_sub(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
        logic [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1])
            return d[DATA_W] ? QMIN : QMAX;
        return d[DATA_W-1:0];
    endfunction

    // floor shift of the product, then saturate
    function automatic logic signed [DATA_W-1:0] q_mul_fin(input logic signed [63:0] p);
        return q_sat48(p[63:16]);
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
    endfunction

endpackage

[design/dense_linear_solver_scaled_pivot.sv]
// load words are taken one per cycle, while in_stall is low, through a four-word queue;
// a word with last set starts the solve, whose length is set by the one-bit-per-cycle
// divider (SIZE*SIZE + SIZE - 1 divisions) plus the memory access steps of the
// one-read, one-write matrix store, then SIZE result words at one per cycle while
// out_stall is low. reset clears the control state and sets the row order to
// identity; the matrix store holds no reset value
`include "dense_linear_solver_scaled_pivot_assert.svh"
module dense_linear_solver_scaled_pivot (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dlssp_pkg::ROW_IN_W-1:0]      row_index,
    input  logic [dlssp_pkg::COL_IN_W-1:0]      col_index,
    input  logic signed [dlssp_pkg::DATA_W-1:0] value,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dlssp_pkg::ROW_IN_W-1:0]      sol_index,
    output logic signed [dlssp_pkg::DATA_W-1:0] solution,
    output logic                                singular,
    output logic                                last_out
);
    import dlssp_pkg::*;

    elem_t q_item;
    logic  q_valid;
    logic  q_pop;
    logic  out_fire;

    assign out_fire = out_valid && !out_stall;

    dlssp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .row_index (row_index),
        .col_index (col_index),
        .value     (value),
        .last      (last),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_pop     (q_pop)
    );

    dlssp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sol_index (sol_index),
        .solution  (solution),
        .singular  (singular),
        .last_out  (last_out)
    );

    `DLSSP_ASSERT(a_pop_needs_word, q_pop |-> q_valid)
    `DLSSP_ASSERT(a_last_index, out_valid && last_out |-> sol_index == ROW_IN_W'(SIZE - 1))
    `DLSSP_ASSERT(a_idx_steps, out_fire && !last_out |=> sol_index == $past(sol_index) + 1'b1)
    `DLSSP_ASSERT(a_flag_steady, out_fire && !last_out |=> singular == $past(singular))

endmodule

[design/dlssp_front.sv]
// front end: takes load words, checks index range, queues them for the sequencer
// depends on dlssp_pkg
module dlssp_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dlssp_pkg::ROW_IN_W-1:0]  row_index,
    input  logic [dlssp_pkg::COL_IN_W-1:0]  col_index,
    input  logic signed [dlssp_pkg::DATA_W-1:0] value,
    input  logic                            last,
    output dlssp_pkg::elem_t                q_item,
    output logic                            q_valid,
    input  logic                            q_pop
);
    import dlssp_pkg::*;

    elem_t            q_mem [Q_DEPTH];
    logic [QP_W-1:0]  wptr_reg, wptr_next;
    logic [QP_W-1:0]  rptr_reg, rptr_next;
    logic [QP_W:0]    cnt_reg, cnt_next;
    logic             push;
    elem_t            item;

    assign in_stall = (cnt_reg == (QP_W+1)'(Q_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = q_mem[rptr_reg];

    always_comb
    begin
        item.wr    = ({1'b0, row_index} < (ROW_IN_W+1)'(SIZE))
                  && ({1'b0, col_index} <= (COL_IN_W+1)'(SIZE));
        item.row   = row_index[IDX_W-1:0];
        item.col   = col_index[COL_W-1:0];
        item.value = value;
        item.last  = last;
    end

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = q_pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + (QP_W+1)'(push) - (QP_W+1)'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

[design/dlssp_div.sv]
// radix-2 restoring divider for q16.16 quotients, one bit per cycle
// depends on dlssp_pkg
module dlssp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  dlssp_pkg::div_req_t req,
    output dlssp_pkg::div_rsp_t rsp
);
    import dlssp_pkg::*;

    logic                run_reg, run_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DV_W-1:0]     dvd_reg, dvd_next;
    logic [DV_W-1:0]     quo_reg, quo_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DATA_W-1:0]   den_reg, den_next;
    logic                neg_reg, neg_next;
    logic                done_reg, done_next;
    logic                dz_reg, dz_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic [DATA_W:0]     rem_sh;
    logic [DATA_W:0]     rem_sub;
    logic                ge;
    logic [DV_W-1:0]     q_new;
    logic [DATA_W-1:0]   n_mag;
    logic [DATA_W-1:0]   d_mag;

    assign rsp.done = done_reg;
    assign rsp.dz   = dz_reg;
    assign rsp.quo  = res_reg;

    always_comb
    begin
        n_mag   = req.num[DATA_W-1] ? DATA_W'(-req.num) : req.num;
        d_mag   = req.den[DATA_W-1] ? DATA_W'(-req.den) : req.den;
        rem_sh  = {rem_reg, dvd_reg[DV_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = !rem_sub[DATA_W];
        q_new   = {quo_reg[DV_W-2:0], ge};

        run_next  = run_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        dz_next   = dz_reg;
        res_next  = res_reg;

        if (req.start)
        begin
            dz_next = (req.den == '0);
            if (req.den == '0)
            begin
                done_next = 1'b1;
                res_next  = req.num[DATA_W-1] ? QMIN : QMAX;
            end
            else
            begin
                run_next = 1'b1;
                cnt_next = CNT_W'(DV_W - 1);
                dvd_next = {n_mag, 16'h0000};
                quo_next = '0;
                rem_next = '0;
                den_next = d_mag;
                neg_next = req.num[DATA_W-1] ^ req.den[DATA_W-1];
            end
        end
        else if (run_reg)
        begin
            rem_next = ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            quo_next = q_new;
            dvd_next = {dvd_reg[DV_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                    res_next = (q_new > DV_W'(33'h1_0000_0000 >> 1)) ? QMIN
                             : DATA_W'(-q_new[DATA_W-1:0]);
                else
                    res_next = (q_new >= DV_W'(33'h1_0000_0000 >> 1)) ? QMAX
                             : q_new[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        dz_reg  <= dz_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

endmodule

[design/dlssp_back.sv]
// back end: matrix memory, elimination and substitution sequencer, result register
// depends on dlssp_pkg and dlssp_div
module dlssp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dlssp_pkg::elem_t                    q_item,
    input  logic                                q_valid,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dlssp_pkg::ROW_IN_W-1:0]      sol_index,
    output logic signed [dlssp_pkg::DATA_W-1:0] solution,
    output logic                                singular,
    output logic                                last_out
);
    import dlssp_pkg::*;

    seq_state_t state_reg, state_next;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_reg;
    logic [ADDR_W-1:0]        raddr;
    logic [ADDR_W-1:0]        waddr;
    logic                     we;
    logic signed [DATA_W-1:0] wdata;

    logic [IDX_W-1:0] order_reg [SIZE];
    logic signed [DATA_W-1:0] scale_reg [SIZE];
    logic signed [DATA_W-1:0] sol_reg [SIZE];

    logic [IDX_W-1:0] i_reg, j_reg, k_reg, piv_reg, r_reg, lk_reg, tmp_reg;
    logic signed [DATA_W-1:0] smax_reg, rmax_reg, mult_reg, opa_reg, opb_reg, acc_reg;
    logic signed [63:0]       prod_reg;
    logic                     sing_reg;

    logic                     ov_reg;
    logic [ROW_IN_W-1:0]      oidx_reg;
    logic signed [DATA_W-1:0] osol_reg;
    logic                     osing_reg;
    logic                     olast_reg;

    logic [IDX_W-1:0]         ord_addr;
    logic [IDX_W-1:0]         ord_rd;
    logic [IDX_W-1:0]         sol_addr;
    logic signed [DATA_W-1:0] sol_rd;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [DATA_W-1:0] mag;
    logic                     out_load;
    div_req_t                 dreq;
    div_rsp_t                 drsp;

    dlssp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign ord_rd    = order_reg[ord_addr];
    assign sol_rd    = sol_reg[sol_addr];
    assign mag       = q_abs(rd_reg);
    assign out_load  = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign sol_index = oidx_reg;
    assign solution  = osol_reg;
    assign singular  = osing_reg;
    assign last_out  = olast_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (q_valid && q_item.last) state_next = S_SC_RD;
            S_SC_RD:   state_next = S_SC_ACC;
            S_SC_ACC:
                if (j_reg == LAST_IDX)
                    state_next = (i_reg == LAST_IDX) ? S_PV_INIT : S_SC_RD;
                else
                    state_next = S_SC_RD;
            S_PV_INIT: state_next = S_PV_ORD;
            S_PV_ORD:  state_next = S_PV_DIV;
            S_PV_DIV:  state_next = S_PV_WAIT;
            S_PV_WAIT:
                if (drsp.done)
                    state_next = (i_reg == LAST_IDX) ? S_SW_A : S_PV_ORD;
            S_SW_A:    state_next = S_SW_B;
            S_SW_B:    state_next = S_SW_C;
            S_SW_C:    state_next = S_EL_ORD;
            S_EL_ORD:  state_next = S_EL_PRD;
            S_EL_PRD:  state_next = S_EL_DIV;
            S_EL_DIV:  state_next = S_EL_DWT;
            S_EL_DWT:  if (drsp.done) state_next = S_EL_RB;
            S_EL_RB:   state_next = S_EL_RA;
            S_EL_RA:   state_next = S_EL_MUL;
            S_EL_MUL:  state_next = S_EL_WR;
            S_EL_WR:   state_next = (j_reg == LAST_IDX) ? S_EL_WM : S_EL_RB;
            S_EL_WM:
                if (i_reg == LAST_IDX)
                    state_next = (k_reg == PEN_IDX) ? S_FW_ORD : S_PV_INIT;
                else
                    state_next = S_EL_ORD;
            S_FW_ORD:  state_next = S_FW_RB;
            S_FW_RB:   state_next = S_FW_RC;
            S_FW_RC:   state_next = S_FW_MUL;
            S_FW_MUL:  state_next = S_FW_WR;
            S_FW_WR:
                if (i_reg == LAST_IDX && k_reg == PEN_IDX)
                    state_next = S_BK_ORD;
                else
                    state_next = S_FW_ORD;
            S_BK_ORD:  state_next = S_BK_SUM;
            S_BK_SUM:  state_next = (i_reg == LAST_IDX) ? S_BK_DRD : S_BK_RD;
            S_BK_RD:   state_next = S_BK_MUL;
            S_BK_MUL:  state_next = S_BK_ACC;
            S_BK_ACC:  state_next = (j_reg == LAST_IDX) ? S_BK_DRD : S_BK_RD;
            S_BK_DRD:  state_next = S_BK_DIV;
            S_BK_DIV:  state_next = S_BK_DWT;
            S_BK_DWT:
                if (drsp.done)
                    state_next = (i_reg == '0) ? S_OUT : S_BK_ORD;
            S_OUT:     if (out_load && j_reg == LAST_IDX) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        q_pop      = 1'b0;
        raddr      = '0;
        waddr      = elem_addr(r_reg, COL_W'(j_reg));
        we         = 1'b0;
        wdata      = q_sub(acc_reg, q_mul_fin(prod_reg));
        ord_addr   = i_reg;
        sol_addr   = j_reg;
        mul_a      = opa_reg;
        mul_b      = opb_reg;
        dreq.start = 1'b0;
        dreq.num   = opa_reg;
        dreq.den   = rd_reg;
        case (state_reg)
            S_IDLE:
            begin
                q_pop = q_valid;
                we    = q_valid && q_item.wr;
                waddr = elem_addr(q_item.row, q_item.col);
                wdata = q_item.value;
            end
            S_SC_RD:  raddr = elem_addr(i_reg, COL_W'(j_reg));
            S_PV_ORD: raddr = elem_addr(ord_rd, COL_W'(k_reg));
            S_PV_DIV:
            begin
                dreq.start = 1'b1;
                dreq.num   = mag;
                dreq.den   = scale_reg[r_reg];
            end
            S_SW_A:   ord_addr = k_reg;
            S_SW_B:   ord_addr = piv_reg;
            S_EL_ORD: raddr = elem_addr(ord_rd, COL_W'(k_reg));
            S_EL_PRD: raddr = elem_addr(lk_reg, COL_W'(k_reg));
            S_EL_DIV: dreq.start = 1'b1;
            S_EL_RB:  raddr = elem_addr(lk_reg, COL_W'(j_reg));
            S_EL_RA:  raddr = elem_addr(r_reg, COL_W'(j_reg));
            S_EL_MUL:
            begin
                mul_a = mult_reg;
                mul_b = opb_reg;
            end
            S_EL_WR:  we = 1'b1;
            S_EL_WM:
            begin
                we    = 1'b1;
                waddr = elem_addr(r_reg, COL_W'(k_reg));
                wdata = mult_reg;
            end
            S_FW_ORD: raddr = elem_addr(ord_rd, COL_W'(k_reg));
            S_FW_RB:
            begin
                ord_addr = k_reg;
                raddr    = elem_addr(ord_rd, RHS_COL);
            end
            S_FW_RC:  raddr = elem_addr(r_reg, RHS_COL);
            S_FW_WR:
            begin
                we    = 1'b1;
                waddr = elem_addr(r_reg, RHS_COL);
            end
            S_BK_ORD: raddr = elem_addr(ord_rd, RHS_COL);
            S_BK_RD:  raddr = elem_addr(r_reg, COL_W'(j_reg));
            S_BK_MUL:
            begin
                mul_a = rd_reg;
                mul_b = sol_rd;
            end
            S_BK_DRD: raddr = elem_addr(r_reg, COL_W'(i_reg));
            S_BK_DIV:
            begin
                dreq.start = 1'b1;
                dreq.num   = acc_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg   <= mem[raddr];
        prod_reg <= mul_a * mul_b;
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sing_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            piv_reg   <= '0;
            r_reg     <= '0;
            lk_reg    <= '0;
            tmp_reg   <= '0;
            for (int n = 0; n < SIZE; n++)
                order_reg[n] <= IDX_W'(n);
        end
        else
        begin
            state_reg <= state_next;
            // flag is cleared as a solve starts
            if (state_reg == S_IDLE && q_valid && q_item.last)
                sing_reg <= 1'b0;
            else if (drsp.done && drsp.dz)
                sing_reg <= 1'b1;
            if (out_load)
                ov_reg <= (state_reg == S_OUT);
            case (state_reg)
                S_IDLE:
                    if (q_valid && q_item.last)
                    begin
                        i_reg    <= '0;
                        j_reg    <= '0;
                        smax_reg <= '0;
                        for (int n = 0; n < SIZE; n++)
                            order_reg[n] <= IDX_W'(n);
                    end
                S_SC_ACC:
                    if (j_reg == LAST_IDX)
                    begin
                        scale_reg[i_reg] <= (mag > smax_reg) ? mag : smax_reg;
                        smax_reg <= '0;
                        j_reg    <= '0;
                        i_reg    <= i_reg + 1'b1;
                        k_reg    <= '0;
                    end
                    else
                    begin
                        if (mag > smax_reg)
                            smax_reg <= mag;
                        j_reg <= j_reg + 1'b1;
                    end
                S_PV_INIT:
                begin
                    rmax_reg <= '0;
                    piv_reg  <= k_reg;
                    i_reg    <= k_reg;
                end
                S_PV_ORD: r_reg <= ord_rd;
                S_PV_WAIT:
                    if (drsp.done)
                    begin
                        if (drsp.quo > rmax_reg)
                        begin
                            rmax_reg <= drsp.quo;
                            piv_reg  <= i_reg;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                S_SW_A: tmp_reg <= ord_rd;
                S_SW_B:
                begin
                    lk_reg <= ord_rd;
                    order_reg[piv_reg] <= tmp_reg;
                end
                S_SW_C:
                begin
                    order_reg[k_reg] <= lk_reg;
                    i_reg <= k_reg + 1'b1;
                end
                S_EL_ORD: r_reg <= ord_rd;
                S_EL_PRD: opa_reg <= rd_reg;
                S_EL_DWT:
                    if (drsp.done)
                    begin
                        mult_reg <= drsp.quo;
                        j_reg    <= k_reg + 1'b1;
                    end
                S_EL_RA:  opb_reg <= rd_reg;
                S_EL_MUL: acc_reg <= rd_reg;
                S_EL_WR:  j_reg <= j_reg + 1'b1;
                S_EL_WM:
                    if (i_reg == LAST_IDX)
                    begin
                        if (k_reg == PEN_IDX)
                        begin
                            k_reg <= '0;
                            i_reg <= IDX_W'(1);
                        end
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                S_FW_ORD: r_reg <= ord_rd;
                S_FW_RB:  opa_reg <= rd_reg;
                S_FW_RC:  opb_reg <= rd_reg;
                S_FW_MUL: acc_reg <= rd_reg;
                S_FW_WR:
                    if (i_reg == LAST_IDX)
                    begin
                        k_reg <= k_reg + 1'b1;
                        // next column starts just below its own diagonal
                        i_reg <= (k_reg == PEN_IDX) ? LAST_IDX : IDX_W'(k_reg + 2'd2);
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                S_BK_ORD: r_reg <= ord_rd;
                S_BK_SUM:
                begin
                    acc_reg <= rd_reg;
                    j_reg   <= i_reg + 1'b1;
                end
                S_BK_ACC:
                begin
                    acc_reg <= q_sub(acc_reg, q_mul_fin(prod_reg));
                    j_reg   <= j_reg + 1'b1;
                end
                S_BK_DWT:
                    if (drsp.done)
                    begin
                        sol_reg[i_reg] <= drsp.quo;
                        i_reg <= i_reg - 1'b1;
                        j_reg <= '0;
                    end
                S_OUT:
                    if (out_load)
                    begin
                        oidx_reg  <= ROW_IN_W'(j_reg);
                        osol_reg  <= sol_rd;
                        osing_reg <= sing_reg;
                        olast_reg <= (j_reg == LAST_IDX);
                        j_reg     <= j_reg + 1'b1;
                    end
                default: ;
            endcase
        end
    end

endmodule

[sim/dense_linear_solver_scaled_pivot_tb.sv]
// testbench for the scaled pivot linear solver: loads matrices word by word,
// predicts every solution word in q16.16 and checks the result stream
// depends on dlssp_pkg and the dense_linear_solver_scaled_pivot top level
module dense_linear_solver_scaled_pivot_tb;

    import dlssp_pkg::*;

    localparam int N           = dlssp_pkg::SIZE;
    localparam int IDLE_LIMIT  = 40000;
    localparam int HOLD_CYCLES = 6000;
    localparam int ITEM_GOAL   = 260;

    typedef struct {
        logic [ROW_IN_W-1:0]      idx;
        logic signed [DATA_W-1:0] sol;
        logic                     sing;
        logic                     lst;
    } sol_word_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [ROW_IN_W-1:0]        row_index;
    logic [COL_IN_W-1:0]        col_index;
    logic signed [DATA_W-1:0]   value;
    logic                       last;
    logic                       out_valid;
    logic                       out_stall;
    logic [ROW_IN_W-1:0]        sol_index;
    logic signed [DATA_W-1:0]   solution;
    logic                       singular;
    logic                       last_out;

    logic signed [DATA_W-1:0]   coef [N][N+1];
    bit                         zero_div;
    sol_word_t                  pending_sols [$];
    int                         errors;
    int                         items_sent;
    int                         burst_left;
    bit                         no_gaps;
    int                         hold_req;
    int                         hold_left;
    int                         idle_cycles;
    int                         stall_phase;

    dense_linear_solver_scaled_pivot uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .row_index (row_index),
        .col_index (col_index),
        .value     (value),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sol_index (sol_index),
        .solution  (solution),
        .singular  (singular),
        .last_out  (last_out)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // q16.16 arithmetic of the solver

    function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
        if (v > longint'(QMAX))
            return QMAX;
        if (v < longint'(QMIN))
            return QMIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] a);
        longint v;
        v = a;
        return clamp32(v < 0 ? -v : v);
    endfunction

    function automatic logic signed [DATA_W-1:0] fx_sub(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        return clamp32(longint'(a) - longint'(b));
    endfunction

    function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp32(p >>> 16);
    endfunction

    // divide by zero saturates by numerator sign and marks the solve singular
    function automatic logic signed [DATA_W-1:0] fx_div(input logic signed [DATA_W-1:0] n,
                                                        input logic signed [DATA_W-1:0] d);
        if (d == 0)
        begin
            zero_div = 1'b1;
            return (n >= 0) ? QMAX : QMIN;
        end
        return clamp32((longint'(n) * 65536) / longint'(d));
    endfunction

    task automatic solve_and_queue();
        logic signed [DATA_W-1:0] scale [N];
        logic signed [DATA_W-1:0] xs    [N];
        int                       order [N];
        logic signed [DATA_W-1:0] best;
        logic signed [DATA_W-1:0] ratio;
        logic signed [DATA_W-1:0] mult;
        logic signed [DATA_W-1:0] acc;
        int                       piv;
        int                       lk;
        int                       r;
        sol_word_t                w;
        zero_div = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            order[i] = i;
            best = 0;
            for (int j = 0; j < N; j++)
                if (mag(coef[i][j]) > best)
                    best = mag(coef[i][j]);
            scale[i] = best;
        end
        for (int k = 0; k < N - 1; k++)
        begin
            best = 0;
            piv = k;
            for (int i = k; i < N; i++)
            begin
                r = order[i];
                ratio = fx_div(mag(coef[r][k]), scale[r]);
                if (ratio > best)
                begin
                    best = ratio;
                    piv = i;
                end
            end
            lk = order[piv];
            order[piv] = order[k];
            order[k] = lk;
            for (int i = k + 1; i < N; i++)
            begin
                r = order[i];
                mult = fx_div(coef[r][k], coef[lk][k]);
                for (int j = k + 1; j < N; j++)
                    coef[r][j] = fx_sub(coef[r][j], fx_mul(mult, coef[lk][j]));
                coef[r][k] = mult;
            end
        end
        for (int k = 0; k < N - 1; k++)
            for (int i = k + 1; i < N; i++)
            begin
                r = order[i];
                coef[r][N] = fx_sub(coef[r][N], fx_mul(coef[r][k], coef[order[k]][N]));
            end
        for (int i = N - 1; i >= 0; i--)
        begin
            r = order[i];
            acc = coef[r][N];
            for (int j = i + 1; j < N; j++)
                acc = fx_sub(acc, fx_mul(coef[r][j], xs[j]));
            xs[i] = fx_div(acc, coef[r][i]);
        end
        for (int i = 0; i < N; i++)
        begin
            w.idx  = ROW_IN_W'(i);
            w.sol  = xs[i];
            w.sing = zero_div;
            w.lst  = (i == N - 1);
            pending_sols.push_back(w);
        end
    endtask

    // drive one load word, wait for it to be taken, then update the prediction
    task automatic send_word(input logic [ROW_IN_W-1:0] r, input logic [COL_IN_W-1:0] c,
                             input logic signed [DATA_W-1:0] v, input logic l);
        @(negedge clk);
        row_index <= r;
        col_index <= c;
        value     <= v;
        last      <= l;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (r < N && c <= N)
            coef[r][c] = v;
        if (l)
            solve_and_queue();
        if (burst_left > 0 || no_gaps)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 30);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 8))
                @(negedge clk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return QMAX;
            2:       return QMIN;
            3, 4:    return $urandom;
            default: return DATA_W'(int'($urandom_range(0, 1048576)) - 524288);
        endcase
    endfunction

    // full reload; a strong diagonal keeps most solves well conditioned
    task automatic load_matrix(input bit strong_diag);
        logic signed [DATA_W-1:0] v;
        for (int i = 0; i < N; i++)
            for (int j = 0; j <= N; j++)
            begin
                v = pick_value();
                if (strong_diag && i == j)
                    v = DATA_W'(($urandom_range(0, 1) ? 1 : -1)
                                * int'($urandom_range(16, 32)) * 65536);
                else if (strong_diag && j < N)
                    v = DATA_W'(int'($urandom_range(0, 262144)) - 131072);
                send_word(ROW_IN_W'(i), COL_IN_W'(j), v, (i == N - 1) && (j == N));
            end
    endtask

    task automatic wait_drained();
        while (pending_sols.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_first_solve();
        load_matrix(1'b1);
    endtask

    task automatic test_extremes();
        send_word(0, 0, QMAX, 1'b0);
        send_word(1, 1, QMIN, 1'b0);
        send_word(2, COL_IN_W'(RHS_COL), QMAX, 1'b0);
        send_word(3, COL_IN_W'(RHS_COL), QMIN, 1'b0);
        send_word(4, 4, 0, 1'b1);
    endtask

    // out of range words are dropped but a last bit still solves
    task automatic test_out_of_range();
        send_word(4'd15, 5'd31, $urandom, 1'b0);
        send_word(4'd8, 5'd3, $urandom, 1'b0);
        send_word(4'd2, 5'd9, $urandom, 1'b0);
        send_word(4'd7, 5'd16, $urandom, 1'b0);
        send_word(4'd9, 5'd0, $urandom, 1'b1);
    endtask

    // an all-zero row gives a zero scale and a zero pivot
    task automatic test_zero_row();
        for (int j = 0; j < N; j++)
            send_word(3, COL_IN_W'(j), 0, j == N - 1);
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        hold_req = HOLD_CYCLES;
        load_matrix(1'b1);
        for (int i = 0; i < 8; i++)
            send_word(ROW_IN_W'($urandom_range(0, N - 1)), COL_IN_W'($urandom_range(0, N)),
                      pick_value(), 1'b0);
        send_word(0, COL_IN_W'(RHS_COL), pick_value(), 1'b1);
    endtask

    task automatic test_pause();
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (20)
            @(posedge clk);
        send_word(5, 5, pick_value(), 1'b1);
    endtask

    task automatic test_random();
        int cnt;
        while (items_sent < ITEM_GOAL)
        begin
            no_gaps = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: stray words, mostly out of range
                cnt = $urandom_range(1, 4);
                for (int i = 0; i < cnt; i++)
                    send_word(ROW_IN_W'($urandom_range(0, 15)),
                              COL_IN_W'($urandom_range(0, 31)), $urandom,
                              i == cnt - 1 && $urandom_range(0, 1));
            end
            else
            begin
                cnt = $urandom_range(1, 14);
                for (int i = 0; i < cnt; i++)
                    send_word(ROW_IN_W'($urandom_range(0, N - 1)),
                              COL_IN_W'($urandom_range(0, N)), pick_value(),
                              i == cnt - 1);
            end
        end
        no_gaps = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        sol_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_sols.size() == 0)
            begin
                errors++;
                $display("%0t unexpected word: got idx %0d sol %h", $time, sol_index, solution);
            end
            else
            begin
                e = pending_sols.pop_front();
                if (sol_index !== e.idx)
                begin
                    errors++;
                    $display("%0t sol_index: expected %0d got %0d", $time, e.idx, sol_index);
                end
                if (solution !== e.sol)
                begin
                    errors++;
                    $display("%0t solution[%0d]: expected %h got %h", $time, e.idx, e.sol,
                             solution);
                end
                if (singular !== e.sing)
                begin
                    errors++;
                    $display("%0t singular: expected %b got %b", $time, e.sing, singular);
                end
                if (last_out !== e.lst)
                begin
                    errors++;
                    $display("%0t last_out: expected %b got %b", $time, e.lst, last_out);
                end
            end
        end
    end

    // receiver stall pattern, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        stall_phase++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case ((stall_phase / 700) % 3)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 9) < 3);
                default: out_stall <= ((stall_phase % 5) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("dense_linear_solver_scaled_pivot: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        row_index = '0;
        col_index = '0;
        value = '0;
        last = 1'b0;
        out_stall = 1'b0;
        errors = 0;
        items_sent = 0;
        burst_left = 4;
        no_gaps = 1'b0;
        hold_req = 0;
        hold_left = 0;
        idle_cycles = 0;
        stall_phase = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_first_solve();
        test_extremes();
        test_out_of_range();
        test_zero_row();
        test_backpressure();
        test_pause();
        test_random();

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (60)
            @(posedge clk);
        if (errors == 0)
            $display("dense_linear_solver_scaled_pivot: match");
        else
            $display("dense_linear_solver_scaled_pivot: mismatch");
        $finish;
    end

endmodule
